@@ hdl/sli_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sorted leaf insert and lookup block.
// No dependencies; every other file imports this package.
package sli_pkg;

    localparam int KEY_BITS          = 32;
    localparam int PAY_IN_BITS       = 32;
    localparam int POS_BITS          = 4;
    localparam int CNT_BITS          = 4;
    localparam int DEF_MAX_RECORDS   = 8;
    localparam int DEF_PAYLOAD_BITS  = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_OVER      = 3'd2,
        ST_NO_ROOM   = 3'd3,
        ST_FOUND     = 3'd4,
        ST_ABSENT    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                  status;
        logic [POS_BITS-1:0]      position;
        logic [PAY_IN_BITS-1:0]   found_payload;
        logic [CNT_BITS-1:0]      entry_count;
    } t_result;

endpackage

@@ hdl/sli_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on sli_pkg for field widths.
interface sli_req_if import sli_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [KEY_BITS-1:0]   key;
    logic [PAY_IN_BITS-1:0]       payload;

    modport source (output valid, kind, key, payload, input ready);
    modport sink   (input valid, kind, key, payload, output ready);
endinterface

interface sli_rsp_if import sli_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [POS_BITS-1:0]          position;
    logic [PAY_IN_BITS-1:0]       found_payload;
    logic [CNT_BITS-1:0]          entry_count;

    modport source (output valid, status, position, found_payload, entry_count, input ready);
    modport sink   (input valid, status, position, found_payload, entry_count, output ready);
endinterface

@@ hdl/sli_ram.sv @@
`timescale 1ns / 1ps
// Record store: one write port, one read port with registered read data.
// Depends on sli_pkg only through the wildcard import convention.
module sli_ram import sli_pkg::*; #(
    parameter int DEPTH = DEF_MAX_RECORDS + 1,
    parameter int WIDTH = KEY_BITS + DEF_PAYLOAD_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

@@ hdl/sli_ctrl.sv @@
`timescale 1ns / 1ps
// Scan sequencer: walks the record store one slot per cycle, ripples the
// insert upward through a carry register, and forms the result word. Uses sli_pkg.
module sli_ctrl import sli_pkg::*; #(
    parameter int MAX_RECORDS  = DEF_MAX_RECORDS,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int DEPTH        = MAX_RECORDS + 1,
    parameter int AW           = $clog2(DEPTH),
    parameter int DW           = KEY_BITS + PAYLOAD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_in_kind,
    input  logic signed [KEY_BITS-1:0] i_in_key,
    input  logic [PAY_IN_BITS-1:0]     i_in_payload,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [DW-1:0]              o_wr_data,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [DW-1:0]              i_rd_data,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output t_result                    o_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_RECORDS);

    t_state                     r_state, n_state;
    logic                       r_kind, n_kind;
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_placed, n_placed;
    logic [AW-1:0]              r_pos, n_pos;
    logic [DW-1:0]              r_carry, n_carry;
    t_result                    r_res, n_res;

    logic signed [KEY_BITS-1:0]  rk;
    logic [PAYLOAD_BITS-1:0]     rp;
    logic [PAYLOAD_BITS+PAY_IN_BITS-1:0] rp_ext;
    logic [PAYLOAD_BITS+PAY_IN_BITS-1:0] in_ext;
    logic [AW-1:0]               idx_inc;
    logic                        last;
    logic                        room;
    logic [CW-1:0]               count_inc;
    logic [AW+POS_BITS-1:0]      idx_ext, pos_ext, tail_ext;
    logic [CW+CNT_BITS-1:0]      cnt_ext, cnt_inc_ext;

    assign rk          = i_rd_data[DW-1 -: KEY_BITS];
    assign rp          = i_rd_data[PAYLOAD_BITS-1:0];
    assign rp_ext      = {{PAY_IN_BITS{1'b0}}, rp};
    assign in_ext      = {{PAYLOAD_BITS{1'b0}}, i_in_payload};
    assign idx_inc     = r_idx + AW'(1);
    assign last        = (CW'(r_idx) + CW'(1)) == r_count;
    assign room        = r_count != DEPTH_C;
    assign count_inc   = r_count + CW'(1);
    assign idx_ext     = {{POS_BITS{1'b0}}, r_idx};
    assign pos_ext     = {{POS_BITS{1'b0}}, r_pos};
    assign tail_ext    = {{POS_BITS{1'b0}}, r_count[AW-1:0]};
    assign cnt_ext     = {{CNT_BITS{1'b0}}, r_count};
    assign cnt_inc_ext = {{CNT_BITS{1'b0}}, count_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_placed <= n_placed;
        r_pos    <= n_pos;
        r_carry  <= n_carry;
        r_res    <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_idx       = r_idx;
        n_count     = r_count;
        n_placed    = r_placed;
        n_pos       = r_pos;
        n_carry     = r_carry;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_idx;
        o_wr_data   = r_carry;
        o_rd_addr   = '0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind   = i_in_kind;
                    n_key    = i_in_key;
                    n_carry  = {i_in_key, in_ext[PAYLOAD_BITS-1:0]};
                    n_idx    = '0;
                    n_placed = 1'b0;
                    n_pos    = '0;
                    n_state  = (r_count == '0) ? S_TAIL : S_SCAN;
                end
            end
            S_SCAN: begin
                o_rd_addr = last ? '0 : idx_inc;
                if (!r_placed && rk == r_key) begin
                    n_res.status        = (r_kind == KIND_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
                    n_res.position      = idx_ext[POS_BITS-1:0];
                    n_res.found_payload = (r_kind == KIND_LOOKUP) ?
                                          rp_ext[PAY_IN_BITS-1:0] : '0;
                    n_res.entry_count   = cnt_ext[CNT_BITS-1:0];
                    n_state             = S_DONE;
                end else if (r_placed || rk > r_key) begin
                    if (r_kind == KIND_LOOKUP) begin
                        n_res.status        = ST_ABSENT;
                        n_res.position      = '0;
                        n_res.found_payload = '0;
                        n_res.entry_count   = cnt_ext[CNT_BITS-1:0];
                        n_state             = S_DONE;
                    end else begin
                        // shift this slot up if there is room: write carry here, carry the old record
                        o_wr_en  = room;
                        n_carry  = i_rd_data;
                        n_placed = 1'b1;
                        if (!r_placed) begin
                            n_pos = r_idx;
                        end
                        if (last) begin
                            n_state = S_TAIL;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                end else if (last) begin
                    n_state = S_TAIL;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_TAIL: begin
                n_res.found_payload = '0;
                n_state             = S_DONE;
                if (r_kind == KIND_LOOKUP) begin
                    n_res.status      = ST_ABSENT;
                    n_res.position    = '0;
                    n_res.entry_count = cnt_ext[CNT_BITS-1:0];
                end else if (!room) begin
                    n_res.status      = ST_NO_ROOM;
                    n_res.position    = '0;
                    n_res.entry_count = cnt_ext[CNT_BITS-1:0];
                end else begin
                    o_wr_en           = 1'b1;
                    o_wr_addr         = r_count[AW-1:0];
                    n_count           = count_inc;
                    n_res.status      = (count_inc > MAX_C) ? ST_OVER : ST_ADDED;
                    n_res.position    = r_placed ? pos_ext[POS_BITS-1:0] :
                                                   tail_ext[POS_BITS-1:0];
                    n_res.entry_count = cnt_inc_ext[CNT_BITS-1:0];
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

@@ hdl/sorted_leaf_insert_lookup.sv @@
`timescale 1ns / 1ps
// Sorted B+ tree leaf with insert and lookup; top level.
// Depends on sli_pkg, sli_if, sli_ram and sli_ctrl.
//
// Usage:
//   i_req carries request words (kind, key, payload); o_rsp carries one
//   response word (status, position, found_payload, entry_count) per request.
//   Records sit in one synchronous store of MAX_RECORDS+1 slots, sorted by
//   signed key. A request walks the occupied slots one per cycle from slot 0,
//   stopping early on a match or, for a lookup, on a greater key; an insert
//   ripples the later records up one slot during the same walk.
//   A request goes from the idle state through the walk, then a tail step
//   unless the walk already formed the result, to the done state, where the
//   response word waits to enter the output register; the next request is
//   taken only after that, so requests are not overlapped. The walk through
//   the single store read port makes the response time grow with the count.
//   Reset clears the record count and control state; store contents are left
//   as they are and never read before being written.
//   A stalled receiver holds the response word in the output register; one
//   more request is then accepted and processed, and waits until it frees.
module sorted_leaf_insert_lookup import sli_pkg::*; #(
    parameter int MAX_RECORDS  = DEF_MAX_RECORDS,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sli_req_if.sink    i_req,
    sli_rsp_if.source  o_rsp
);

    localparam int DEPTH = MAX_RECORDS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = KEY_BITS + PAYLOAD_BITS;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          res_valid;
    logic          res_ready;
    t_result       res;

    logic          r_out_valid;
    t_result       r_out;

    sli_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DW),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sli_ctrl #(
        .MAX_RECORDS  (MAX_RECORDS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .DEPTH        (DEPTH),
        .AW           (AW),
        .DW           (DW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .o_in_ready   (i_req.ready),
        .i_in_kind    (i_req.kind),
        .i_in_key     (i_req.key),
        .i_in_payload (i_req.payload),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.position      = r_out.position;
    assign o_rsp.found_payload = r_out.found_payload;
    assign o_rsp.entry_count   = r_out.entry_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while a walk was still running");

    a_payload_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != ST_FOUND |-> o_rsp.found_payload == '0)
        else $error("nonzero payload on a response other than found");

    a_over_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ST_OVER |->
            o_rsp.entry_count == CNT_BITS'(MAX_RECORDS + 1))
        else $error("over-capacity status with wrong record count");

endmodule
